>>> rtl/core/ftws_pkg.sv
// ----------------------------------------------------------------------------
// Frame time window statistics package
// Shared widths, constants, command codes and control structs.
// ----------------------------------------------------------------------------
package ftws_pkg;

	localparam int WINDOW_DEPTH = 64;
	localparam int PTR_W        = $clog2(WINDOW_DEPTH);
	localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

	localparam int TIME_W    = 24;
	localparam int TARGET_W  = 24;
	localparam int RATE_W    = 27;
	localparam int SAMPLES_W = 7;
	localparam int COUNT_W   = 32;
	localparam int SUM_W     = TIME_W + CNT_W;
	localparam int DIV_W     = (SUM_W > RATE_W) ? SUM_W : RATE_W;
	localparam int DIVCNT_W  = $clog2(DIV_W + 1);

	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	localparam logic [TARGET_W-1:0] TARGET_RESET   = TARGET_W'(16667);
	localparam logic [DIV_W-1:0]    RATE_NUMERATOR = DIV_W'(100000000);

	localparam logic ACT_RECORD = 1'b0;
	localparam logic ACT_CLEAR  = 1'b1;

	localparam logic DIV_SEL_AVG  = 1'b0;
	localparam logic DIV_SEL_RATE = 1'b1;

	localparam logic REG_TARGET = 1'b0;

	typedef struct packed {
		logic load_in;
		logic clear;
		logic record;
		logic sweep;
		logic div_start;
		logic div_sel;
		logic take_avg;
		logic take_rate;
		logic load_out;
	} ftws_cmd_t;

	typedef struct packed {
		logic act;
		logic sweep_done;
		logic div_done;
		logic avg_zero;
	} ftws_sts_t;

endpackage

>>> rtl/core/ftws_in_if.sv
// ----------------------------------------------------------------------------
// Frame input channel
// Valid/ready channel carrying one command and one frame duration.
// ----------------------------------------------------------------------------
interface ftws_in_if;
	import ftws_pkg::*;

	logic              valid;
	logic              ready;
	logic              action;
	logic [TIME_W-1:0] frame_time_us;

	modport source (output valid, output action, output frame_time_us, input ready);
	modport sink (input valid, input action, input frame_time_us, output ready);

endinterface

>>> rtl/core/ftws_out_if.sv
// ----------------------------------------------------------------------------
// Statistics output channel
// Valid/ready channel carrying one set of window statistics.
// ----------------------------------------------------------------------------
interface ftws_out_if;
	import ftws_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [TIME_W-1:0]    avg_time_us;
	logic [TIME_W-1:0]    min_time_us;
	logic [TIME_W-1:0]    max_time_us;
	logic [RATE_W-1:0]    rate_centi_fps;
	logic [SAMPLES_W-1:0] samples_held;
	logic [COUNT_W-1:0]   frames_total;
	logic [COUNT_W-1:0]   frames_dropped;

	modport source (
		output valid, output avg_time_us, output min_time_us, output max_time_us,
		output rate_centi_fps, output samples_held, output frames_total,
		output frames_dropped, input ready
	);
	modport sink (
		input valid, input avg_time_us, input min_time_us, input max_time_us,
		input rate_centi_fps, input samples_held, input frames_total,
		input frames_dropped, output ready
	);

endinterface

>>> rtl/core/frame_time_window_stats.sv
// ----------------------------------------------------------------------------
// Frame time window statistics
// A record reads the window one entry per cycle through the memory read
// port, then runs two serial divisions (mean, then frame rate; the rate
// division is skipped on a zero mean). A clear runs no division.
// One item is in work at a time; the result register frees the input side.
// Asynchronous reset empties the window, zeroes counters and the held rate.
// ----------------------------------------------------------------------------
module frame_time_window_stats (
	input  logic                              clk,
	input  logic                              arst_n,
	ftws_in_if.sink                           frame,
	ftws_out_if.source                        stats,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ftws_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [ftws_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [ftws_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready
);
	import ftws_pkg::*;

	logic [TARGET_W-1:0] target_q;
	logic                reg_sel;
	ftws_cmd_t           cmd;
	ftws_sts_t           sts;

	assign reg_sel = paddr[APB_ADDR_W-1];
	assign pready  = 1'b1;
	assign prdata  = (reg_sel == REG_TARGET) ? APB_DATA_W'(target_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_RESET;
		end else if (psel && penable && pwrite && (reg_sel == REG_TARGET)) begin
			target_q <= pwdata[TARGET_W-1:0];
		end
	end

	ftws_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (frame.valid),
		.in_ready  (frame.ready),
		.out_valid (stats.valid),
		.out_ready (stats.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ftws_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.in_action      (frame.action),
		.in_time        (frame.frame_time_us),
		.target         (target_q),
		.avg_time_us    (stats.avg_time_us),
		.min_time_us    (stats.min_time_us),
		.max_time_us    (stats.max_time_us),
		.rate_centi_fps (stats.rate_centi_fps),
		.samples_held   (stats.samples_held),
		.frames_total   (stats.frames_total),
		.frames_dropped (stats.frames_dropped)
	);

	// Only one item is in work, so a transfer always drops ready next cycle.
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		(frame.valid && frame.ready) |=> !frame.ready)
		else $error("input ready while an item is in work");

	a_empty_window: assert property (@(posedge clk) disable iff (!arst_n)
		(stats.valid && (stats.samples_held == '0)) |->
		((stats.avg_time_us == '0) && (stats.max_time_us == '0) &&
		 (stats.min_time_us == '1)))
		else $error("empty window result fields wrong");

	a_mean_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(stats.valid && (stats.samples_held != '0)) |->
		((stats.min_time_us <= stats.avg_time_us) &&
		 (stats.avg_time_us <= stats.max_time_us)))
		else $error("mean outside min/max");

	a_dropped_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		stats.valid |-> (stats.frames_dropped <= stats.frames_total))
		else $error("dropped count above total count");

endmodule

>>> rtl/core/ftws_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ftws_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/ftws_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ftws_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [ftws_pkg::DIV_W-1:0]     dividend,
	input  logic [ftws_pkg::DIV_W-1:0]     divisor,
	output logic                           done,
	output logic [ftws_pkg::DIV_W-1:0]     quotient
);
	import ftws_pkg::*;

	logic [DIVCNT_W-1:0] cnt_q;
	logic                done_q;
	logic [DIV_W-1:0]    rem_q;
	logic [DIV_W-1:0]    quo_q;
	logic [DIV_W-1:0]    dvs_q;
	logic [DIV_W:0]      trial;
	logic                fits;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign fits  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == DIVCNT_W'(1));
			if (start) begin
				cnt_q <= DIVCNT_W'(DIV_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			if (fits) begin
				rem_q <= DIV_W'(trial - {1'b0, dvs_q});
			end else begin
				rem_q <= trial[DIV_W-1:0];
			end
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> rtl/core/ftws_ctrl.sv
// ----------------------------------------------------------------------------
// Frame statistics controller
// Sequences clear, record, sweep, the two divisions and the output transfer.
// ----------------------------------------------------------------------------
module ftws_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  ftws_pkg::ftws_sts_t sts,
	output ftws_pkg::ftws_cmd_t cmd
);
	import ftws_pkg::*;

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_DECODE   = 3'd1;
	localparam logic [2:0] ST_SWEEP    = 3'd2;
	localparam logic [2:0] ST_DIV_AVG  = 3'd3;
	localparam logic [2:0] ST_CHECK    = 3'd4;
	localparam logic [2:0] ST_DIV_RATE = 3'd5;
	localparam logic [2:0] ST_LOAD     = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (sts.act == ACT_CLEAR) begin
					cmd.clear = 1'b1;
					state_d   = ST_LOAD;
				end else begin
					cmd.record = 1'b1;
					state_d    = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_done) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_SEL_AVG;
					state_d       = ST_DIV_AVG;
				end
			end
			ST_DIV_AVG: begin
				if (sts.div_done) begin
					cmd.take_avg = 1'b1;
					state_d      = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.avg_zero) begin
					state_d = ST_LOAD;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_SEL_RATE;
					state_d       = ST_DIV_RATE;
				end
			end
			ST_DIV_RATE: begin
				if (sts.div_done) begin
					cmd.take_rate = 1'b1;
					state_d       = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

>>> rtl/core/ftws_dp.sv
// ----------------------------------------------------------------------------
// Frame statistics datapath
// Window memory, counters, sweep accumulators, divider and result registers.
// ----------------------------------------------------------------------------
module ftws_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ftws_pkg::ftws_cmd_t             cmd,
	output ftws_pkg::ftws_sts_t             sts,
	input  logic                            in_action,
	input  logic [ftws_pkg::TIME_W-1:0]     in_time,
	input  logic [ftws_pkg::TARGET_W-1:0]   target,
	output logic [ftws_pkg::TIME_W-1:0]     avg_time_us,
	output logic [ftws_pkg::TIME_W-1:0]     min_time_us,
	output logic [ftws_pkg::TIME_W-1:0]     max_time_us,
	output logic [ftws_pkg::RATE_W-1:0]     rate_centi_fps,
	output logic [ftws_pkg::SAMPLES_W-1:0]  samples_held,
	output logic [ftws_pkg::COUNT_W-1:0]    frames_total,
	output logic [ftws_pkg::COUNT_W-1:0]    frames_dropped
);
	import ftws_pkg::*;

	logic                 act_q;
	logic [TIME_W-1:0]    time_q;
	logic [PTR_W-1:0]     ptr_q;
	logic [CNT_W-1:0]     fill_q;
	logic [COUNT_W-1:0]   total_q;
	logic [COUNT_W-1:0]   drop_q;
	logic [RATE_W-1:0]    rate_q;
	logic [CNT_W-1:0]     idx_q;
	logic                 rd_vld_s1;
	logic [SUM_W-1:0]     sum_q;
	logic [TIME_W-1:0]    mn_q;
	logic [TIME_W-1:0]    mx_q;
	logic [TIME_W-1:0]    avg_q;
	logic [TIME_W-1:0]    rd_data;
	logic                 issue;
	logic [TIME_W+1:0]    time_x2;
	logic [TARGET_W+1:0]  target_x3;
	logic                 is_dropped;
	logic [DIV_W-1:0]     div_dvd;
	logic [DIV_W-1:0]     div_dvs;
	logic [DIV_W-1:0]     div_quo;
	logic                 div_done;

	logic [TIME_W-1:0]    avg_o_q;
	logic [TIME_W-1:0]    min_o_q;
	logic [TIME_W-1:0]    max_o_q;
	logic [RATE_W-1:0]    rate_o_q;
	logic [SAMPLES_W-1:0] samples_o_q;
	logic [COUNT_W-1:0]   total_o_q;
	logic [COUNT_W-1:0]   drop_o_q;

	assign issue      = cmd.sweep && (idx_q < fill_q);
	assign time_x2    = {1'b0, time_q, 1'b0};
	assign target_x3  = {2'b00, target} + {1'b0, target, 1'b0};
	assign is_dropped = (time_x2 > target_x3);

	ftws_ram #(
		.WIDTH (TIME_W),
		.DEPTH (WINDOW_DEPTH)
	) u_window (
		.clk   (clk),
		.we    (cmd.record),
		.waddr (ptr_q),
		.wdata (time_q),
		.raddr (idx_q[PTR_W-1:0]),
		.rdata (rd_data)
	);

	assign div_dvd = (cmd.div_sel == DIV_SEL_RATE) ? RATE_NUMERATOR : DIV_W'(sum_q);
	assign div_dvs = (cmd.div_sel == DIV_SEL_RATE) ? DIV_W'(avg_q) : DIV_W'(fill_q);

	ftws_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q     <= '0;
			fill_q    <= '0;
			total_q   <= '0;
			drop_q    <= '0;
			rate_q    <= '0;
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (cmd.clear) begin
				ptr_q   <= '0;
				fill_q  <= '0;
				total_q <= '0;
				drop_q  <= '0;
				rate_q  <= '0;
			end else if (cmd.record) begin
				ptr_q <= (ptr_q == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
				if (fill_q != CNT_W'(WINDOW_DEPTH)) begin
					fill_q <= fill_q + 1'b1;
				end
				if (total_q != '1) begin
					total_q <= total_q + 1'b1;
				end
				if (is_dropped && (drop_q != '1)) begin
					drop_q <= drop_q + 1'b1;
				end
			end else if (cmd.take_rate) begin
				rate_q <= div_quo[RATE_W-1:0];
			end

			if (cmd.record) begin
				idx_q     <= '0;
				rd_vld_s1 <= 1'b0;
			end else begin
				if (issue) begin
					idx_q <= idx_q + 1'b1;
				end
				rd_vld_s1 <= issue;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			act_q  <= in_action;
			time_q <= in_time;
		end

		if (cmd.clear) begin
			avg_q <= '0;
			mn_q  <= '1;
			mx_q  <= '0;
		end else if (cmd.record) begin
			sum_q <= '0;
			mn_q  <= '1;
			mx_q  <= '0;
		end else if (rd_vld_s1) begin
			sum_q <= sum_q + SUM_W'(rd_data);
			if (rd_data < mn_q) begin
				mn_q <= rd_data;
			end
			if (rd_data > mx_q) begin
				mx_q <= rd_data;
			end
		end else if (cmd.take_avg) begin
			avg_q <= div_quo[TIME_W-1:0];
		end

		if (cmd.load_out) begin
			avg_o_q     <= avg_q;
			min_o_q     <= mn_q;
			max_o_q     <= mx_q;
			rate_o_q    <= rate_q;
			samples_o_q <= SAMPLES_W'(fill_q);
			total_o_q   <= total_q;
			drop_o_q    <= drop_q;
		end
	end

	assign sts.act        = act_q;
	assign sts.sweep_done = (idx_q == fill_q) && !rd_vld_s1;
	assign sts.div_done   = div_done;
	assign sts.avg_zero   = (avg_q == '0);

	assign avg_time_us    = avg_o_q;
	assign min_time_us    = min_o_q;
	assign max_time_us    = max_o_q;
	assign rate_centi_fps = rate_o_q;
	assign samples_held   = samples_o_q;
	assign frames_total   = total_o_q;
	assign frames_dropped = drop_o_q;

endmodule
